/* hdl/spp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_pkg
// Shared constants, types and the microprogram of the shortest palindrome
// prepend block.
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int CHAR_W  = 8;
  localparam int STEP_W  = 4;
  localparam int COND_W  = 3;
  localparam int OP_W    = 4;

  // Microprogram step addresses.
  localparam logic [STEP_W-1:0] ST_LOAD    = 4'd0;
  localparam logic [STEP_W-1:0] ST_SETUP   = 4'd1;
  localparam logic [STEP_W-1:0] ST_INIT    = 4'd2;
  localparam logic [STEP_W-1:0] ST_TEST    = 4'd3;
  localparam logic [STEP_W-1:0] ST_CHECK   = 4'd4;
  localparam logic [STEP_W-1:0] ST_FOUND   = 4'd5;
  localparam logic [STEP_W-1:0] ST_EMIT_RD = 4'd6;
  localparam logic [STEP_W-1:0] ST_EMIT    = 4'd7;
  localparam logic [STEP_W-1:0] ST_NEXT    = 4'd8;
  localparam logic [STEP_W-1:0] ST_CLEAR   = 4'd9;
  localparam logic [STEP_W-1:0] ST_NOTHING = 4'd10;

  // Jump conditions.
  localparam logic [COND_W-1:0] CND_ALWAYS    = 3'd0;
  localparam logic [COND_W-1:0] CND_IN_LAST   = 3'd1;
  localparam logic [COND_W-1:0] CND_END_ZERO  = 3'd2;
  localparam logic [COND_W-1:0] CND_LO_GE_HI  = 3'd3;
  localparam logic [COND_W-1:0] CND_MISMATCH  = 3'd4;
  localparam logic [COND_W-1:0] CND_FULL_PAL  = 3'd5;
  localparam logic [COND_W-1:0] CND_OUT_BUSY  = 3'd6;
  localparam logic [COND_W-1:0] CND_HI_AT_END = 3'd7;

  // Datapath operations.
  localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
  localparam logic [OP_W-1:0] OP_SETUP   = 4'd2;
  localparam logic [OP_W-1:0] OP_INIT    = 4'd3;
  localparam logic [OP_W-1:0] OP_CHECK   = 4'd4;
  localparam logic [OP_W-1:0] OP_FOUND   = 4'd5;
  localparam logic [OP_W-1:0] OP_EMIT    = 4'd6;
  localparam logic [OP_W-1:0] OP_NOTHING = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR   = 4'd8;

  typedef struct packed {
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] tgt_t;
    logic [STEP_W-1:0] tgt_f;
    logic [OP_W-1:0]   op;
  } ctl_t;

  // What the sequencer hands the datapath each cycle.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            taken;
  } dp_ctl_t;

  // Status flags the datapath returns for condition evaluation.
  typedef struct packed {
    logic in_last_acc;
    logic end_zero;
    logic lo_ge_hi;
    logic mismatch;
    logic full_pal;
    logic out_busy;
    logic hi_at_end;
  } sts_t;

  // The control store: one word per step.
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t w;
    unique case (step)
      ST_LOAD:    w = '{CND_IN_LAST,   ST_SETUP,   ST_LOAD,    OP_LOAD};
      ST_SETUP:   w = '{CND_ALWAYS,    ST_INIT,    ST_INIT,    OP_SETUP};
      ST_INIT:    w = '{CND_END_ZERO,  ST_FOUND,   ST_TEST,    OP_INIT};
      ST_TEST:    w = '{CND_LO_GE_HI,  ST_FOUND,   ST_CHECK,   OP_NONE};
      ST_CHECK:   w = '{CND_MISMATCH,  ST_INIT,    ST_TEST,    OP_CHECK};
      ST_FOUND:   w = '{CND_FULL_PAL,  ST_NOTHING, ST_EMIT_RD, OP_FOUND};
      ST_EMIT_RD: w = '{CND_ALWAYS,    ST_EMIT,    ST_EMIT,    OP_NONE};
      ST_EMIT:    w = '{CND_OUT_BUSY,  ST_EMIT,    ST_NEXT,    OP_EMIT};
      ST_NEXT:    w = '{CND_HI_AT_END, ST_CLEAR,   ST_EMIT_RD, OP_NONE};
      ST_CLEAR:   w = '{CND_ALWAYS,    ST_LOAD,    ST_LOAD,    OP_CLEAR};
      ST_NOTHING: w = '{CND_OUT_BUSY,  ST_NOTHING, ST_CLEAR,   OP_NOTHING};
      default:    w = '{CND_ALWAYS,    ST_LOAD,    ST_LOAD,    OP_NONE};
    endcase
    return w;
  endfunction

endpackage

/* hdl/spp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_if
// Valid/ready channels carrying string bytes in and prepend results out.
// ----------------------------------------------------------------------------
interface spp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface spp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] prepend_char;
  logic       nothing_needed;
  logic       run_end;
  logic       overflowed;

  modport source (output valid, output prepend_char, output nothing_needed,
                  output run_end, output overflowed, input ready);
  modport sink   (input valid, input prepend_char, input nothing_needed,
                  input run_end, input overflowed, output ready);
endinterface

/* hdl/spp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module spp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

/* hdl/spp_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module spp_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  spp_pkg::sts_t    sts,
  output spp_pkg::dp_ctl_t dp_ctl
);
  import spp_pkg::*;

  logic [STEP_W-1:0] upc_r;
  logic [STEP_W-1:0] upc_nxt;
  ctl_t              word;
  logic              taken;

  assign word = ucode(upc_r);

  always_comb begin
    unique case (word.cond)
      CND_ALWAYS:    taken = 1'b1;
      CND_IN_LAST:   taken = sts.in_last_acc;
      CND_END_ZERO:  taken = sts.end_zero;
      CND_LO_GE_HI:  taken = sts.lo_ge_hi;
      CND_MISMATCH:  taken = sts.mismatch;
      CND_FULL_PAL:  taken = sts.full_pal;
      CND_OUT_BUSY:  taken = sts.out_busy;
      CND_HI_AT_END: taken = sts.hi_at_end;
      default:       taken = 1'b1;
    endcase
  end

  assign upc_nxt      = taken ? word.tgt_t : word.tgt_f;
  assign dp_ctl.op    = word.op;
  assign dp_ctl.taken = taken;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_LOAD;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

/* hdl/spp_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_dp
// Datapath: string buffer, length and index registers, output register.
// ----------------------------------------------------------------------------
module spp_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  spp_pkg::dp_ctl_t            dp_ctl,
  output spp_pkg::sts_t               sts,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [spp_pkg::CHAR_W-1:0]  in_char,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [spp_pkg::CHAR_W-1:0]  out_char,
  output logic                        out_nothing,
  output logic                        out_end,
  output logic                        out_ovf
);
  import spp_pkg::*;

  logic [LEN_W-1:0]  len_r,  len_nxt;
  logic              ovf_r,  ovf_nxt;
  logic [ADDR_W-1:0] end_r,  end_nxt;
  logic [ADDR_W-1:0] lo_r,   lo_nxt;
  logic [ADDR_W-1:0] hi_r,   hi_nxt;

  logic              out_valid_r,   out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r,    out_char_nxt;
  logic              out_nothing_r, out_nothing_nxt;
  logic              out_end_r,     out_end_nxt;
  logic              out_ovf_r,     out_ovf_nxt;

  logic              accept;
  logic              room;
  logic              we;
  logic [CHAR_W-1:0] rd_lo;
  logic [CHAR_W-1:0] rd_hi;

  spp_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (len_r[ADDR_W-1:0]),
    .wdata   (in_char),
    .raddr_a (lo_r),
    .raddr_b (hi_r),
    .rdata_a (rd_lo),
    .rdata_b (rd_hi)
  );

  assign in_ready = (dp_ctl.op == OP_LOAD);
  assign accept   = in_valid && in_ready;
  assign room     = (len_r < LEN_W'(MAX_LEN));
  assign we       = accept && room;

  assign sts.in_last_acc = accept && in_last;
  assign sts.end_zero    = (end_r == '0);
  assign sts.lo_ge_hi    = (lo_r >= hi_r);
  assign sts.mismatch    = (rd_lo != rd_hi);
  assign sts.full_pal    = ((LEN_W'(end_r) + LEN_W'(1)) == len_r);
  assign sts.out_busy    = out_valid_r && !out_ready;
  assign sts.hi_at_end   = (hi_r == end_r);

  always_comb begin
    len_nxt         = len_r;
    ovf_nxt         = ovf_r;
    end_nxt         = end_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_char_nxt    = out_char_r;
    out_nothing_nxt = out_nothing_r;
    out_end_nxt     = out_end_r;
    out_ovf_nxt     = out_ovf_r;

    unique case (dp_ctl.op)
      OP_LOAD: begin
        if (accept) begin
          if (room) begin
            len_nxt = len_r + LEN_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      OP_SETUP: begin
        end_nxt = ADDR_W'(len_r - LEN_W'(1));
      end
      OP_INIT: begin
        lo_nxt = '0;
        hi_nxt = end_r;
      end
      OP_CHECK: begin
        if (dp_ctl.taken) begin
          end_nxt = end_r - ADDR_W'(1);
        end else begin
          lo_nxt = lo_r + ADDR_W'(1);
          hi_nxt = hi_r - ADDR_W'(1);
        end
      end
      OP_FOUND: begin
        hi_nxt = ADDR_W'(len_r - LEN_W'(1));
      end
      OP_EMIT: begin
        if (!dp_ctl.taken) begin
          out_valid_nxt   = 1'b1;
          out_char_nxt    = rd_hi;
          out_nothing_nxt = 1'b0;
          out_end_nxt     = (hi_r == end_r + ADDR_W'(1));
          out_ovf_nxt     = ovf_r;
          hi_nxt          = hi_r - ADDR_W'(1);
        end
      end
      OP_NOTHING: begin
        if (!dp_ctl.taken) begin
          out_valid_nxt   = 1'b1;
          out_char_nxt    = '0;
          out_nothing_nxt = 1'b1;
          out_end_nxt     = 1'b1;
          out_ovf_nxt     = ovf_r;
        end
      end
      OP_CLEAR: begin
        len_nxt = '0;
        ovf_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r         <= end_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    out_char_r    <= out_char_nxt;
    out_nothing_r <= out_nothing_nxt;
    out_end_r     <= out_end_nxt;
    out_ovf_r     <= out_ovf_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign out_nothing = out_nothing_r;
  assign out_end     = out_end_r;
  assign out_ovf     = out_ovf_r;

endmodule

/* hdl/shortest_palindrome_prepend_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_palindrome_prepend_top
// Finds the characters to prepend to a byte string so that it reads the same
// both ways, by locating its longest palindromic prefix.
// ----------------------------------------------------------------------------
// Usage
//   The in_ch channel takes one byte of the string per item, one item per
//   cycle while loading; last_char marks the final byte. Up to MAX_LEN bytes
//   are kept; later bytes are dropped and the results carry overflowed.
//   After the final item the block stops taking items and searches the
//   buffer, shrinking the candidate prefix until it reads the same both
//   ways. Each pair comparison takes a test step and a check step on the
//   dual-read buffer. The results then leave on out_ch, the remaining
//   suffix last byte first, each item passing read, emit and next steps
//   before the next item is read, the last one flagged run_end. A
//   string that is already a palindrome gives one item with nothing_needed.
//   The output register holds an item until the receiver takes it; while it
//   stalls the sequencer simply waits. Once the final result is in the
//   output register the block is ready for the next string, even while that
//   item still waits. Reset (synchronous, active low) empties the buffer
//   and drops any item not yet taken.
// ----------------------------------------------------------------------------
module shortest_palindrome_prepend_top (
  input logic      clk,
  input logic      rst_n,
  spp_in_if.sink   in_ch,
  spp_out_if.source out_ch
);
  import spp_pkg::*;

  dp_ctl_t dp_ctl;
  sts_t    sts;

  // The sequencer steps through the control store; the datapath acts on
  // each control word and reports the flags that steer the next jump.
  spp_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .sts    (sts),
    .dp_ctl (dp_ctl)
  );

  spp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .dp_ctl      (dp_ctl),
    .sts         (sts),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_char     (in_ch.char_in),
    .in_last     (in_ch.last_char),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_char    (out_ch.prepend_char),
    .out_nothing (out_ch.nothing_needed),
    .out_end     (out_ch.run_end),
    .out_ovf     (out_ch.overflowed)
  );

endmodule

/* hdl/spp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spp_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module spp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_nothing,
  input logic       out_end
);

  // A stalled result item keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_end))
    else $error("result item changed while stalled");

  // A palindrome report is always the single, final item of its string.
  a_nothing_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nothing |-> out_end)
    else $error("nothing_needed item without run_end");

  a_nothing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nothing |-> out_char == 8'd0)
    else $error("nothing_needed item with a nonzero character");

  // Reset drops any pending result.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind shortest_palindrome_prepend_top spp_checker u_spp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_char    (out_ch.prepend_char),
  .out_nothing (out_ch.nothing_needed),
  .out_end     (out_ch.run_end)
);

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shortest palindrome prepend block. Strings are
// fed byte by byte over the input channel. A behavioural predictor in the
// bench works out which bytes must be prepended to each string, and the
// monitor compares every result item with the oldest prediction. Both
// channels idle and stall at random throughout the run.
// ----------------------------------------------------------------------------
module tb;

  import spp_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int TAIL_CYCLES  = 100;
  localparam int RANDOM_ITEMS = 170;

  // One byte of a string as it waits to be driven.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } string_byte_t;

  // One prepend result, field for field as it leaves the block.
  typedef struct packed {
    logic [CHAR_W-1:0] prepend_char;
    logic              nothing_needed;
    logic              run_end;
    logic              overflowed;
  } prepend_result_t;

  logic clk;
  logic rst_n;

  spp_in_if  in_ch ();
  spp_out_if out_ch ();

  shortest_palindrome_prepend_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Bytes waiting to be driven, and prepend results still owed by the block.
  string_byte_t    pending_bytes [$];
  prepend_result_t expected_prepends [$];

  // The predictor's own copy of the string buffer.
  logic [CHAR_W-1:0] text_buf [0:MAX_LEN-1];
  int                text_len;
  logic              text_ovf;

  int queued_items;
  int bytes_accepted;
  int errors;
  int cycles;

  // Idle control for the two sides. A calm spell forces a run of zero gaps,
  // so that back-to-back traffic is seen as well as ragged traffic.
  int in_gap;
  int in_calm;
  int out_stall;
  int out_calm;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Mostly no gap or a short one; now and then a long one.
  function automatic int draw_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Takes one accepted byte into the predictor's buffer. On the final byte it
  // finds the longest palindromic prefix and queues the bytes that follow it,
  // last byte first. A one-byte prefix always reads the same both ways, so the
  // search is bound to stop at index zero at the latest.
  function automatic void predict_prepend(input logic [CHAR_W-1:0] ch,
                                          input logic last);
    int n;
    int pal_end;
    int lo;
    int hi;
    bit found;
    prepend_result_t res;

    if (text_len < MAX_LEN) begin
      text_buf[text_len] = ch;
      text_len++;
    end else begin
      text_ovf = 1'b1;
    end
    if (!last) return;

    n       = text_len;
    pal_end = n - 1;
    found   = 1'b0;
    while (!found) begin
      lo    = 0;
      hi    = pal_end;
      found = 1'b1;
      while (lo < hi) begin
        if (text_buf[lo] != text_buf[hi]) found = 1'b0;
        lo++;
        hi--;
      end
      if (!found) pal_end--;
    end

    if (pal_end == n - 1) begin
      // The whole string is already a palindrome: a single flagged item.
      res = '{prepend_char: '0, nothing_needed: 1'b1, run_end: 1'b1,
              overflowed: text_ovf};
      expected_prepends.push_back(res);
    end else begin
      for (int i = n - 1; i > pal_end; i--) begin
        res = '{prepend_char: text_buf[i], nothing_needed: 1'b0,
                run_end: (i == pal_end + 1), overflowed: text_ovf};
        expected_prepends.push_back(res);
      end
    end
    text_len = 0;
    text_ovf = 1'b0;
  endfunction

  task automatic push_byte(input logic [CHAR_W-1:0] ch, input logic last);
    string_byte_t b;
    b = '{ch: ch, last: last};
    pending_bytes.push_back(b);
    queued_items++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  // Builds a string whose first pal_len bytes form a palindrome, followed by
  // random bytes. A narrow alphabet of two symbols makes longer palindromic
  // prefixes and near misses far more likely than uniform bytes would.
  task automatic queue_string(input int len, input int pal_len, input bit narrow);
    logic [CHAR_W-1:0] text [0:79];
    logic [CHAR_W-1:0] sym_a;
    logic [CHAR_W-1:0] sym_b;
    sym_a = $urandom;
    sym_b = $urandom;
    for (int i = 0; i < len; i++) begin
      if (i < pal_len && i >= (pal_len + 1) / 2) text[i] = text[pal_len - 1 - i];
      else if (narrow) text[i] = $urandom_range(0, 1) ? sym_a : sym_b;
      else text[i] = $urandom;
      push_byte(text[i], i == len - 1);
    end
  endtask

  // Driver: puts the next byte up once the current one has been taken and the
  // drawn gap has run out. Each input gets a single assignment per edge.
  always @(posedge clk) begin : drive_bytes
    string_byte_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_prepend(in_ch.char_in, in_ch.last_char);
        bytes_accepted++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the item until the block takes it.
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        nxt = pending_bytes.pop_front();
        in_ch.char_in   <= nxt.ch;
        in_ch.last_char <= nxt.last;
        in_ch.valid     <= 1'b1;
        in_gap = draw_gap(in_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every result item taken and stalls the receiver at
  // random, both after an item and while the block is still searching, so
  // that stalls land on the first result of a string as well as on later ones.
  always @(posedge clk) begin : watch_results
    prepend_result_t got;
    prepend_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{prepend_char: out_ch.prepend_char,
                nothing_needed: out_ch.nothing_needed,
                run_end: out_ch.run_end, overflowed: out_ch.overflowed};
        if (expected_prepends.size() == 0) begin
          report_mismatch($sformatf("result %p arrived with none expected", got));
        end else begin
          want = expected_prepends.pop_front();
          if (got.prepend_char !== want.prepend_char)
            report_mismatch($sformatf("prepend_char %h, expected %h",
                                      got.prepend_char, want.prepend_char));
          if (got.nothing_needed !== want.nothing_needed)
            report_mismatch($sformatf("nothing_needed %b, expected %b",
                                      got.nothing_needed, want.nothing_needed));
          if (got.run_end !== want.run_end)
            report_mismatch($sformatf("run_end %b, expected %b",
                                      got.run_end, want.run_end));
          if (got.overflowed !== want.overflowed)
            report_mismatch($sformatf("overflowed %b, expected %b",
                                      got.overflowed, want.overflowed));
        end
        out_stall = draw_gap(out_calm);
      end else if (out_stall > 0) begin
        out_stall--;
      end else if (!out_ch.valid && $urandom_range(0, 7) == 0) begin
        out_stall = draw_gap(out_calm);
      end
      out_ch.ready <= (out_stall == 0);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int len;
    int goal;

    rst_n           = 1'b0;
    text_len        = 0;
    text_ovf        = 1'b0;
    queued_items    = 0;
    bytes_accepted  = 0;
    errors          = 0;
    cycles          = 0;
    in_gap          = 0;
    in_calm         = 0;
    out_stall       = 0;
    out_calm        = 0;

    // Directed strings: single bytes at both extremes of the byte range, a
    // two-byte string with no palindromic prefix beyond its first byte, short
    // palindromes, a string with a three-byte palindromic prefix, and the
    // classic case where the longest palindromic prefix is most of the string.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hA5, 1'b1);
    queue_text("zz");
    queue_text("aba");
    queue_text("abac");
    queue_text("dcb");
    queue_text("aacecaaa");

    // One string that overruns the buffer, its final byte among those
    // dropped. Half the time the stored part is a palindrome, otherwise the
    // prefix is short and nearly the whole buffer comes back reversed.
    queue_string(MAX_LEN + 2, $urandom_range(0, 1) ? MAX_LEN : $urandom_range(1, 6),
                 1'b1);

    // Random strings, mostly short with the odd medium one, until the run
    // holds about the intended number of items in all.
    goal = RANDOM_ITEMS;
    while (queued_items < goal) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      queue_string(len, $urandom_range(1, len), $urandom_range(0, 3) != 0);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_accepted < queued_items) @(posedge clk);
    while (expected_prepends.size() != 0) @(posedge clk);
    // A little longer, so that any stray result after the last one is caught.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
